>>> hw/rtl/dsc_pkg.sv
// dsc_pkg: shared types and constants for the day serial to calendar block
// used by every rtl file of the block except dsc_if; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   // field widths of the request channel and of the queue item
   localparam int DayNumberWidth   = 23;
   localparam int DayFractionWidth = 32;
   localparam int DaysWidth        = 22;
   localparam int SecsWidth        = 17;

   // range limits of the serial date
   localparam logic signed [22:0] DateHigh = 23'sd2958465;
   localparam logic signed [22:0] DateLow  = -23'sd657434;

   // calendar constants
   localparam int DaysToEpoch = 693959;
   localparam int Days400     = 146097;
   localparam int Days100     = 36524;
   localparam int Days4       = 1461;
   localparam int Days1       = 365;
   localparam int SecsPerDay  = 86400;
   localparam int SecsPerHour = 3600;
   localparam int SecsPerMin  = 60;
   localparam int DaysPerWeek = 7;

   // reciprocal estimates, q = (x * recip) >> shift, low by at most one
   localparam int ShiftDays  = 22;
   localparam int Recip400   = (1 << ShiftDays) / Days400;
   localparam int RecipWeek  = (1 << ShiftDays) / DaysPerWeek;
   localparam int ShiftHour  = 17;
   localparam int RecipHour  = (1 << ShiftHour) / SecsPerHour;
   localparam int ShiftFour  = 16;
   localparam int Recip4     = (1 << ShiftFour) / Days4;
   localparam int ShiftMin   = 12;
   localparam int RecipMin   = (1 << ShiftMin) / SecsPerMin;

   // cumulative day count at the start of each month, common year
   localparam logic [8:0] MonthStart [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

   // one beat held in the queue between front and back
   typedef struct packed {
      logic                 ok;
      logic [DaysWidth-1:0] days;
      logic [SecsWidth-1:0] secs;
   } dsc_item_type;

   typedef struct packed {
      logic         valid;
      dsc_item_type item;
   } dsc_beat_type;

endpackage

`default_nettype wire

>>> hw/rtl/dsc_if.sv
// dsc_if: valid/ready channel interfaces for request and response beats
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface dsc_req_if;
   logic               valid;
   logic               ready;
   logic signed [22:0] day_number;
   logic [31:0]        day_fraction;

   modport source (output valid, day_number, day_fraction, input ready);
   modport sink   (input valid, day_number, day_fraction, output ready);
endinterface

interface dsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        date_valid;
   logic [13:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;
   logic [4:0]  hour;
   logic [5:0]  minute;
   logic [5:0]  second;
   logic [2:0]  weekday;
   logic [8:0]  year_day;

   modport source (output valid, date_valid, year, month, day_of_month, hour,
                   minute, second, weekday, year_day, input ready);
   modport sink   (input valid, date_valid, year, month, day_of_month, hour,
                   minute, second, weekday, year_day, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/day_serial_to_calendar.sv
// day_serial_to_calendar: ole automation date to calendar fields
// top level; uses dsc_pkg, dsc_if, dsc_front, dsc_queue and dsc_back
//
// usage
//   req_chan carries a signed day count since 1899-12-30 and the unsigned
//   magnitude of the day fraction; rsp_chan returns date_valid, year,
//   month, day_of_month, hour, minute, second, weekday (sunday 1) and
//   year_day, one response beat for every request beat, in order.
//   when the response side is ready, one beat is accepted every cycle.
//   the front (range check and rounding, then the second-of-day
//   multiplier) is two stages, a two-entry queue follows, and the back
//   is six stages whose last one is the response register.
//   when rsp_chan.ready is low the back holds, the queue fills, and
//   req_chan.ready drops once the front cannot hand over its beat; no
//   beat is lost or repeated.
//   reset clears all valid state and the queue; nothing else needs it.
`timescale 1ns / 1ps
`default_nettype none

module day_serial_to_calendar #(
   parameter int FRACTION_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   dsc_req_if.sink   req_chan,
   dsc_rsp_if.source rsp_chan
);
   import dsc_pkg::*;

   dsc_beat_type push;
   dsc_beat_type pop;
   logic         push_ready;
   logic         pop_ready;

   dsc_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .push      (push),
      .push_ready(push_ready)
   );

   dsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_ready(push_ready),
      .pop       (pop),
      .pop_ready (pop_ready)
   );

   dsc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .pop_ready(pop_ready),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

>>> hw/rtl/dsc_front.sv
// dsc_front: accepts request beats, range check, rounding to the second,
// day count from year zero and second of day; uses dsc_pkg and dsc_if
`timescale 1ns / 1ps
`default_nettype none

module dsc_front #(
   parameter int FRACTION_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   dsc_req_if.sink            req_chan,
   output dsc_pkg::dsc_beat_type push,
   input  wire logic          push_ready
);
   import dsc_pkg::*;

   localparam int FB = FRACTION_BITS;
   localparam longint unsigned FracOne = 64'd1 << FB;
   localparam longint unsigned HalfSec = (FracOne + 64'd86400) / 64'd172800;

   logic                 adv;
   logic [FB+31:0]       frac_ext;
   logic [FB-1:0]        frac;
   logic [22:0]          dn_bits;
   logic [22:0]          mag;
   logic [FB+23:0]       rnd;
   logic [FB+16:0]       sec_prod;

   logic                 f1_valid_ff;
   logic                 f1_ok_ff, f1_ok_in;
   logic                 f1_neg_ff, f1_neg_in;
   logic [DaysWidth-1:0] f1_whole_ff, f1_whole_in;
   logic [FB-1:0]        f1_frac_ff, f1_frac_in;
   logic                 f2_valid_ff;
   dsc_item_type         f2_item_ff, f2_item_in;

   // both stages move together unless the queue refuses the last one
   assign adv            = !f2_valid_ff || push_ready;
   assign req_chan.ready = adv;

   // range check and rounding by half a second in the direction of magnitude
   always_comb begin
      frac_ext    = {{FB{1'b0}}, req_chan.day_fraction};
      frac        = frac_ext[FB-1:0];
      dn_bits     = req_chan.day_number;
      f1_neg_in   = dn_bits[22];
      mag         = f1_neg_in ? (23'd0 - dn_bits) : dn_bits;
      f1_ok_in    = !((req_chan.day_number > DateHigh) ||
                      (req_chan.day_number == DateHigh && frac != '0) ||
                      (req_chan.day_number < DateLow) ||
                      (req_chan.day_number == DateLow && frac != '0));
      rnd         = {1'b0, mag, {FB{1'b0}}} + (FB+24)'(frac) + (FB+24)'(HalfSec);
      f1_whole_in = rnd[FB+21:FB];
      f1_frac_in  = rnd[FB-1:0];
   end

   // signed day count from year zero and truncated second of the day
   always_comb begin
      sec_prod        = (FB+17)'(f1_frac_ff) * (FB+17)'(SecsPerDay);
      f2_item_in.ok   = f1_ok_ff;
      f2_item_in.days = f1_neg_ff ? (DaysWidth'(DaysToEpoch) - f1_whole_ff)
                                  : (DaysWidth'(DaysToEpoch) + f1_whole_ff);
      f2_item_in.secs = sec_prod[FB+16:FB];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= req_chan.valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ok_ff    <= f1_ok_in;
         f1_neg_ff   <= f1_neg_in;
         f1_whole_ff <= f1_whole_in;
         f1_frac_ff  <= f1_frac_in;
         f2_item_ff  <= f2_item_in;
      end
   end

   assign push = '{valid: f2_valid_ff, item: f2_item_ff};

endmodule

`default_nettype wire

>>> hw/rtl/dsc_queue.sv
// dsc_queue: two-entry queue decoupling the front from the back
// uses dsc_pkg for the beat type
`timescale 1ns / 1ps
`default_nettype none

module dsc_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsc_pkg::dsc_beat_type push,
   output logic                       push_ready,
   output dsc_pkg::dsc_beat_type      pop,
   input  wire logic                  pop_ready
);
   import dsc_pkg::*;

   localparam int Depth = 2;

   dsc_item_type     mem [Depth];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != 2'(Depth);
   assign pop        = '{valid: count_ff != 2'd0, item: mem[rd_ptr_ff]};
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/dsc_back.sv
// dsc_back: six-stage calendar breakdown of a day count and second of day
// uses dsc_pkg and dsc_if; the last stage is the response register
`timescale 1ns / 1ps
`default_nettype none

module dsc_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dsc_pkg::dsc_beat_type pop,
   output logic                       pop_ready,
   dsc_rsp_if.source                  rsp_chan
);
   import dsc_pkg::*;

   typedef struct packed {
      logic        ok;
      logic [21:0] days;
      logic [16:0] secs;
      logic [26:0] p400;
      logic [41:0] p7;
      logic [22:0] ph;
   } s1_type;

   typedef struct packed {
      logic        ok;
      logic [17:0] am;
      logic [4:0]  y400;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [11:0] rh;
   } s2_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  y400;
      logic [1:0]  cen;
      logic [15:0] x;
      logic [21:0] px;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [11:0] rh;
      logic [18:0] pm;
   } s3_type;

   typedef struct packed {
      logic        ok;
      logic [4:0]  y400;
      logic [1:0]  cen;
      logic [4:0]  y4;
      logic        leap4;
      logic [10:0] d4;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } s4_type;

   typedef struct packed {
      logic        ok;
      logic [13:0] year;
      logic        lyear;
      logic [8:0]  d4n;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } s5_type;

   typedef struct packed {
      logic        date_valid;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [2:0]  weekday;
      logic [8:0]  year_day;
   } s6_type;

   logic       adv;
   logic [6:1] valid_ff;
   s1_type     s1_ff, s1_in;
   s2_type     s2_ff, s2_in;
   s3_type     s3_ff, s3_in;
   s4_type     s4_ff, s4_in;
   s5_type     s5_ff, s5_in;
   s6_type     s6_ff, s6_in;

   // whole pipeline moves unless the response register is held
   assign adv       = !valid_ff[6] || rsp_chan.ready;
   assign pop_ready = adv;

   // stage 1: reciprocal products for 400-year block, weekday and hour
   always_comb begin
      s1_in.ok   = pop.item.ok;
      s1_in.days = pop.item.days;
      s1_in.secs = pop.item.secs;
      s1_in.p400 = 27'(pop.item.days) * 27'(Recip400);
      s1_in.p7   = 42'(pop.item.days - 22'd1) * 42'(RecipWeek);
      s1_in.ph   = 23'(pop.item.secs) * 23'(RecipHour);
   end

   // stage 2: remainders with one correction step each
   always_comb begin
      logic [4:0]  q400;
      logic [21:0] rem400;
      logic [19:0] q7;
      logic [21:0] rem7;
      logic [21:0] days_m1;
      logic [5:0]  qh;
      logic [16:0] remh;
      q400    = s1_ff.p400[26:22];
      rem400  = s1_ff.days - 22'(q400) * 22'(Days400);
      if (rem400 >= 22'(Days400)) begin
         q400   = q400 + 5'd1;
         rem400 = rem400 - 22'(Days400);
      end
      days_m1 = s1_ff.days - 22'd1;
      q7      = s1_ff.p7[41:22];
      rem7    = days_m1 - 22'(q7) * 22'(DaysPerWeek);
      if (rem7 >= 22'(DaysPerWeek)) begin
         rem7 = rem7 - 22'(DaysPerWeek);
      end
      qh      = s1_ff.ph[22:17];
      remh    = s1_ff.secs - 17'(qh) * 17'(SecsPerHour);
      if (remh >= 17'(SecsPerHour)) begin
         qh   = qh + 6'd1;
         remh = remh - 17'(SecsPerHour);
      end
      s2_in.ok      = s1_ff.ok;
      s2_in.am      = rem400[17:0];
      s2_in.y400    = q400;
      s2_in.weekday = rem7[2:0] + 3'd1;
      s2_in.hour    = qh[4:0];
      s2_in.rh      = remh[11:0];
   end

   // stage 3: century inside the 400-year block, then 4-year product
   always_comb begin
      logic [17:0] am1;
      logic [1:0]  cen;
      logic [17:0] b;
      logic [15:0] x;
      am1 = s2_ff.am - 18'd1;
      if (s2_ff.am == 18'd0) begin
         cen = 2'd0;
      end else if (am1 >= 18'(3 * Days100)) begin
         cen = 2'd3;
      end else if (am1 >= 18'(2 * Days100)) begin
         cen = 2'd2;
      end else if (am1 >= 18'(Days100)) begin
         cen = 2'd1;
      end else begin
         cen = 2'd0;
      end
      b = am1 - 18'(cen) * 18'(Days100);
      x = (cen != 2'd0) ? (b[15:0] + 16'd1) : s2_ff.am[15:0];
      s3_in.ok      = s2_ff.ok;
      s3_in.y400    = s2_ff.y400;
      s3_in.cen     = cen;
      s3_in.x       = x;
      s3_in.px      = 22'(x) * 22'(Recip4);
      s3_in.weekday = s2_ff.weekday;
      s3_in.hour    = s2_ff.hour;
      s3_in.rh      = s2_ff.rh;
      s3_in.pm      = 19'(s2_ff.rh) * 19'(RecipMin);
   end

   // stage 4: 4-year block and day inside it; first block of a
   // non-leap century has no leap day
   always_comb begin
      logic [5:0]  y4;
      logic [15:0] d;
      logic [6:0]  qm;
      logic [11:0] remm;
      y4 = s3_ff.px[21:16];
      d  = s3_ff.x - 16'(y4) * 16'(Days4);
      if (d >= 16'(Days4)) begin
         y4 = y4 + 6'd1;
         d  = d - 16'(Days4);
      end
      qm   = s3_ff.pm[18:12];
      remm = s3_ff.rh - 12'(qm) * 12'(SecsPerMin);
      if (remm >= 12'(SecsPerMin)) begin
         qm   = qm + 7'd1;
         remm = remm - 12'(SecsPerMin);
      end
      s4_in.ok      = s3_ff.ok;
      s4_in.y400    = s3_ff.y400;
      s4_in.cen     = s3_ff.cen;
      s4_in.y4      = y4[4:0];
      s4_in.leap4   = !(s3_ff.cen != 2'd0 && y4 == 6'd0);
      s4_in.d4      = s4_in.leap4 ? d[10:0] : (s3_ff.x[10:0] - 11'd1);
      s4_in.weekday = s3_ff.weekday;
      s4_in.hour    = s3_ff.hour;
      s4_in.minute  = qm[5:0];
      s4_in.second  = remm[5:0];
   end

   // stage 5: year inside the 4-year block and the year number
   always_comb begin
      logic [1:0]  yr;
      logic [10:0] d4n;
      if (s4_ff.leap4) begin
         if (s4_ff.d4 >= 11'(3 * Days1 + 1)) begin
            yr = 2'd3;
         end else if (s4_ff.d4 >= 11'(2 * Days1 + 1)) begin
            yr = 2'd2;
         end else if (s4_ff.d4 >= 11'(Days1 + 1)) begin
            yr = 2'd1;
         end else begin
            yr = 2'd0;
         end
         d4n = (yr == 2'd0) ? s4_ff.d4
                            : (s4_ff.d4 - 11'd1 - 11'(yr) * 11'(Days1));
      end else begin
         if (s4_ff.d4 >= 11'(3 * Days1)) begin
            yr = 2'd3;
         end else if (s4_ff.d4 >= 11'(2 * Days1)) begin
            yr = 2'd2;
         end else if (s4_ff.d4 >= 11'(Days1)) begin
            yr = 2'd1;
         end else begin
            yr = 2'd0;
         end
         d4n = s4_ff.d4 - 11'(yr) * 11'(Days1);
      end
      s5_in.ok      = s4_ff.ok;
      s5_in.year    = 14'(s4_ff.y400) * 14'd400 + 14'(s4_ff.cen) * 14'd100 +
                      14'(s4_ff.y4) * 14'd4 + 14'(yr);
      s5_in.lyear   = s4_ff.leap4 && yr == 2'd0;
      s5_in.d4n     = d4n[8:0];
      s5_in.weekday = s4_ff.weekday;
      s5_in.hour    = s4_ff.hour;
      s5_in.minute  = s4_ff.minute;
      s5_in.second  = s4_ff.second;
   end

   // stage 6: month lookup, feb 29 on its own, zeros for an invalid date
   always_comb begin
      logic [8:0] dd;
      logic [3:0] cnt;
      logic       feb29;
      feb29 = s5_ff.lyear && s5_ff.d4n == 9'd59;
      dd    = s5_ff.d4n + 9'd1 - 9'(s5_ff.lyear && s5_ff.d4n >= 9'd60);
      cnt   = 4'd0;
      for (int k = 1; k < 12; k++) begin
         cnt = cnt + 4'(dd > MonthStart[k]);
      end
      s6_in = '0;
      if (s5_ff.ok) begin
         s6_in.date_valid   = 1'b1;
         s6_in.year         = s5_ff.year;
         s6_in.month        = feb29 ? 4'd2 : (cnt + 4'd1);
         s6_in.day_of_month = feb29 ? 5'd29 : 5'(dd - MonthStart[cnt]);
         s6_in.hour         = s5_ff.hour;
         s6_in.minute       = s5_ff.minute;
         s6_in.second       = s5_ff.second;
         s6_in.weekday      = s5_ff.weekday;
         s6_in.year_day     = s5_ff.d4n + 9'd1;
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[5:1], pop.valid};
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
      end
   end

   // response register drives the channel
   assign rsp_chan.valid        = valid_ff[6];
   assign rsp_chan.date_valid   = s6_ff.date_valid;
   assign rsp_chan.year         = s6_ff.year;
   assign rsp_chan.month        = s6_ff.month;
   assign rsp_chan.day_of_month = s6_ff.day_of_month;
   assign rsp_chan.hour         = s6_ff.hour;
   assign rsp_chan.minute       = s6_ff.minute;
   assign rsp_chan.second       = s6_ff.second;
   assign rsp_chan.weekday      = s6_ff.weekday;
   assign rsp_chan.year_day     = s6_ff.year_day;

   // an invalid date leaves every calendar field at zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] && !s6_ff.date_valid |->
         s6_ff.year == 14'd0 && s6_ff.month == 4'd0 && s6_ff.weekday == 3'd0 &&
         s6_ff.year_day == 9'd0 && s6_ff.day_of_month == 5'd0)
      else $error("invalid date with nonzero fields");

   // a valid date has fields in calendar range
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[6] && s6_ff.date_valid |->
         s6_ff.month >= 4'd1 && s6_ff.month <= 4'd12 &&
         s6_ff.day_of_month >= 5'd1 && s6_ff.weekday >= 3'd1 &&
         s6_ff.weekday <= 3'd7 && s6_ff.year_day >= 9'd1 && s6_ff.hour <= 5'd23)
      else $error("calendar field out of range");

   // a beat taken from the queue lands in the first stage
   a_pop_lands: assert property (@(posedge clock) disable iff (reset)
      pop.valid && pop_ready |=> valid_ff[1])
      else $error("queue beat lost on entry to the back end");

endmodule

`default_nettype wire
